### rtl/core/mec_pkg.sv
// Shared constants for the escape-time counter core.
// No dependencies; imported by mec_mul and mandelbrot_escape_count_core.
package mec_pkg;

    // Default coordinate format: signed Q4.28 in 32 bits.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 28;

    // Iteration count and limit register.
    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] ITER_CAP = 17'd65536;

    // Result stream: the count, zero-filled to whole bytes.
    localparam int M_TDATA_W = ((COUNT_W + 7) / 8) * 8;

    // Default width of one multiplier operand: a value of magnitude up to two.
    localparam int MUL_W_DEF = FRAC_BITS_DEF + 3;

endpackage

### rtl/core/mec_mul.sv
// Registered signed multiplier shared by every product of the iteration.
// Depends on mec_pkg for its default operand width.
module mec_mul #(
    parameter int MUL_W = mec_pkg::MUL_W_DEF
) (
    input  logic                        aclk,
    input  logic signed [MUL_W-1:0]     op_a,
    input  logic signed [MUL_W-1:0]     op_b,
    output logic signed [2*MUL_W-1:0]   prod_reg
);
    import mec_pkg::*;

    logic signed [2*MUL_W-1:0] prod_next;

    // Exact product; both operands are sign-extended to the full width.
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

### rtl/core/mandelbrot_escape_count_core.sv
// Escape-time counter for one point of the complex plane, in fixed point.
// Depends on mec_pkg and mec_mul (the shared multiplier).
//
// Usage: a point c arrives as one transaction on the s_ stream, with c_real
// in the low COORD_WIDTH bits of s_tdata and c_imag above it. The core starts
// with z equal to c and a count of one, then repeatedly applies z = z*z + c
// until |z|^2 exceeds four or the iteration limit is reached. The final count,
// from 1 to the limit plus one, leaves as one transaction on the m_ stream.
// The iteration limit is written through cfg_wr_en/cfg_wr_data. The user
// must write it only while the core is idle; the core does not enforce this.
// Values above 65536 act as 65536 and zero returns a count of one.
// Sequence: one update steps through ST_CHECK, ST_SQ_I, ST_CROSS and ST_UPD,
// since the single multiplier forms zr*zr, zi*zi and zr*zi in turn. A point
// that leaves the radius-two box or reaches the limit finishes from ST_CHECK,
// and one that fails the squared-magnitude test finishes from ST_CROSS; both
// pass through ST_DONE, which raises the result. s_tready is high only while no
// point is in work. A result waiting for m_tready does not hold up the next
// point; if the receiver still stalls when the next result is ready, the core
// holds that result. Reset (synchronous, aresetn low) drops any point in work
// and any pending result, and sets the iteration limit to 65536.
module mandelbrot_escape_count_core #(
    parameter int COORD_WIDTH = mec_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = mec_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: the iteration limit.
    input  logic                               cfg_wr_en,
    input  logic [mec_pkg::COUNT_W-1:0]        cfg_wr_data,
    // Input stream. tdata from bit 0: c_real, c_imag, zero fill.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // Result stream. tdata from bit 0: count, zero fill.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mec_pkg::M_TDATA_W-1:0]      m_tdata
);
    import mec_pkg::*;

    // z carries four more integer bits than c; the multiplier operand only
    // needs to hold a magnitude of two, as larger values escape first.
    localparam int Z_W   = COORD_WIDTH + 4;
    localparam int MUL_W = FRAC_BITS + 3;
    localparam int P_W   = 2 * MUL_W;
    localparam int S_W   = ((P_W > Z_W) ? P_W : Z_W) + 1;

    localparam logic signed [S_W-1:0] TWO_S =
        {{(S_W-FRAC_BITS-2){1'b0}}, 2'b10, {FRAC_BITS{1'b0}}};
    localparam logic signed [S_W-1:0] LIM_S =
        {{(S_W-FRAC_BITS-3){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQ_I,
        ST_CROSS,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [COUNT_W-1:0]           iter_limit_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [COUNT_W-1:0]           count_out_reg;
    logic                         m_tvalid_reg;
    logic signed [COORD_WIDTH-1:0] cr_reg;
    logic signed [COORD_WIDTH-1:0] ci_reg;
    logic signed [Z_W-1:0]        zr_reg;
    logic signed [Z_W-1:0]        zi_reg;
    logic signed [S_W-1:0]        sr_reg;
    logic signed [S_W-1:0]        si_reg;

    logic signed [MUL_W-1:0]      op_a;
    logic signed [MUL_W-1:0]      op_b;
    logic signed [P_W-1:0]        prod_reg;

    logic [COUNT_W-1:0]           limit;
    logic                         limit_hit;
    logic signed [S_W-1:0]        zr_s;
    logic signed [S_W-1:0]        zi_s;
    logic                         out_of_box;
    logic signed [S_W-1:0]        sq_val;
    logic signed [S_W-1:0]        cross_val;
    logic signed [S_W-1:0]        mag_sq;
    logic                         mag_escape;
    logic signed [Z_W-1:0]        zr_next;
    logic signed [Z_W-1:0]        zi_next;

    // Limits above the cap behave as the cap.
    assign limit     = (iter_limit_reg > ITER_CAP) ? ITER_CAP : iter_limit_reg;
    // The count is one more than the updates run so far.
    assign limit_hit = (count_reg > limit);

    assign zr_s = S_W'(zr_reg);
    assign zi_s = S_W'(zi_reg);
    // A component beyond two always escapes; this also keeps every product
    // within the multiplier operand width.
    assign out_of_box = (zr_s > TWO_S) || (zr_s < -TWO_S) ||
                        (zi_s > TWO_S) || (zi_s < -TWO_S);

    // Arithmetic shifts give floor division, i.e. truncation toward minus
    // infinity. The cross product drops one bit fewer, which doubles it.
    assign sq_val     = S_W'(prod_reg >>> FRAC_BITS);
    assign cross_val  = S_W'(prod_reg >>> (FRAC_BITS - 1));
    assign mag_sq     = sr_reg + sq_val;
    assign mag_escape = (mag_sq > LIM_S);

    assign zr_next = Z_W'(sr_reg - si_reg + S_W'(cr_reg));
    assign zi_next = Z_W'(cross_val + S_W'(ci_reg));

    // Operand selection for the shared multiplier: zr*zr, then zi*zi, then zr*zi.
    always_comb begin
        op_a = MUL_W'(zr_reg);
        op_b = MUL_W'(zr_reg);
        case (state_reg)
            ST_SQ_I: begin
                op_a = MUL_W'(zi_reg);
                op_b = MUL_W'(zi_reg);
            end
            ST_CROSS: begin
                op_a = MUL_W'(zr_reg);
                op_b = MUL_W'(zi_reg);
            end
            default: begin
                op_a = MUL_W'(zr_reg);
                op_b = MUL_W'(zr_reg);
            end
        endcase
    end

    mec_mul #(
        .MUL_W (MUL_W)
    ) u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // Sequencer: state, operands and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            iter_limit_reg <= ITER_CAP;
        end else begin
            if (cfg_wr_en) begin
                iter_limit_reg <= cfg_wr_data;
            end

            // In the finishing state the output register is handled below.
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cr_reg    <= s_tdata[COORD_WIDTH-1:0];
                        ci_reg    <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                        zr_reg    <= Z_W'($signed(s_tdata[COORD_WIDTH-1:0]));
                        zi_reg    <= Z_W'($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
                        count_reg <= COUNT_W'(1);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    // The multiplier is forming zr*zr in this cycle.
                    if (limit_hit || out_of_box) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_SQ_I;
                    end
                end
                ST_SQ_I: begin
                    sr_reg    <= sq_val;
                    state_reg <= ST_CROSS;
                end
                ST_CROSS: begin
                    si_reg <= sq_val;
                    if (mag_escape) begin
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    zr_reg    <= zr_next;
                    zi_reg    <= zi_next;
                    count_reg <= count_reg + COUNT_W'(1);
                    state_reg <= ST_CHECK;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        count_out_reg <= count_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-COUNT_W){1'b0}}, count_out_reg};

`ifndef NO_ASSERTIONS
    // A newly accepted point always starts with a count of one.
    a_start_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (count_reg == COUNT_W'(1) && state_reg == ST_CHECK))
        else $error("point did not start with a count of one");

    // The count never runs past one more than the effective limit.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |->
            ({1'b0, count_reg} <= ({1'b0, limit} + (COUNT_W+1)'(1))))
        else $error("iteration count ran past the limit");

    // A result is only raised from the finishing state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finishing state");

    // A delivered count is never zero.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (count_out_reg != '0))
        else $error("result count of zero");
`endif

endmodule
